// ===== hdl/slst_pkg.sv =====
// Shared types, widths and codes for the sorted list engine.
package slst_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int POS_W    = 4;
    localparam int LEN_W    = 5;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_SWAP   = 2'd2,
        MODE_EVENS  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_SH_RD,
        S_INS_SH_WR,
        S_INS_PUT,
        S_DEL,
        S_SWP_B,
        S_SWP_W,
        S_SWP_W2,
        S_EV,
        S_RESP
    } state_t;

    typedef struct packed {
        mode_t                     mode;
        logic signed [DATA_W-1:0]  value;
        logic [POS_W-1:0]          position_a;
        logic [POS_W-1:0]          position_b;
    } cmd_beat_t;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [DATA_W-1:0]  item_value;
        logic                      item_valid;
        logic                      last_item;
        logic [LEN_W-1:0]          length;
    } res_beat_t;

    // Flags and index steps from the shared compare unit
    typedef struct packed {
        logic             ge;
        logic             even;
        logic             last;
        logic [CNT_W-1:0] inc;
        logic [IDX_W-1:0] dec;
    } unit_res_t;

endpackage

// ===== hdl/slst_mem.sv =====
// Element store: one write port, one read port with registered read data.
module slst_mem (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [slst_pkg::IDX_W-1:0]        wr_addr,
    input  logic signed [slst_pkg::DATA_W-1:0] wr_data,
    input  logic                              rd_en,
    input  logic [slst_pkg::IDX_W-1:0]        rd_addr,
    output logic signed [slst_pkg::DATA_W-1:0] rd_data
);
    import slst_pkg::*;

    logic signed [DATA_W-1:0] mem [CAPACITY];
    logic signed [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data holds between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/slst_unit.sv =====
// Shared compare unit: signed compare, parity test and index step.
module slst_unit (
    input  logic signed [slst_pkg::DATA_W-1:0] elem,
    input  logic signed [slst_pkg::DATA_W-1:0] value,
    input  logic [slst_pkg::IDX_W-1:0]         idx,
    input  logic [slst_pkg::CNT_W-1:0]         cnt,
    output slst_pkg::unit_res_t                res
);
    import slst_pkg::*;

    logic [CNT_W-1:0] inc;

    assign inc = CNT_W'(idx) + CNT_W'(1);

    always_comb
    begin
        res.ge   = (elem >= value);
        res.even = ~elem[0];
        res.inc  = inc;
        res.last = (inc == cnt);
        res.dec  = idx - IDX_W'(1);
    end

endmodule

// ===== hdl/sorted_list_engine.sv =====
// Sorted list engine: command beats in, status and readout beats out.
//
// Channels: cmd carries mode, value and two positions; res carries status,
// item_value, item_valid, last_item and length. A beat moves on a rising
// edge with valid high and stall low. cmd_stall is high whenever a command
// is in progress; one command is worked at a time.
// Insert, delete and swap each return one status beat; read evens returns
// one beat per even element (last_item on the final one), or one empty
// beat when there is none.
// A full-list insert or an out-of-range delete or swap goes straight to
// its status beat. The store has one registered read port, so search,
// close-up and readout visit one element per cycle (readout only while
// the receiver does not stall), and the insert shift moves each element
// with a read state and a write state, S_INS_SH_RD and S_INS_SH_WR.
// Reset clears the element count, the sequencer and the result valid flag;
// the store contents are not cleared. When the receiver stalls, the result
// register holds its beat and the sequencer waits before loading the next.
module sorted_list_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  slst_pkg::cmd_beat_t  cmd_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output slst_pkg::res_beat_t  res_data
);
    import slst_pkg::*;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [IDX_W-1:0]          pos_reg, pos_next;
    logic signed [DATA_W-1:0]  val_reg, val_next;
    logic signed [DATA_W-1:0]  pend_reg, pend_next;
    logic                      pend_valid_reg, pend_valid_next;
    status_t                   status_reg, status_next;
    logic                      out_valid_reg, out_valid_next;
    res_beat_t                 out_reg, out_next;

    logic                      wr_en, rd_en;
    logic [IDX_W-1:0]          wr_addr, rd_addr;
    logic signed [DATA_W-1:0]  wr_data, rd_data;
    logic [IDX_W-1:0]          unit_idx;
    unit_res_t                 ur;
    logic                      accept, out_free, emit;
    res_beat_t                 emit_beat;
    logic                      pa_bad, pb_bad, ev_hold;

    slst_mem u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    slst_unit u_unit (
        .elem  (rd_data),
        .value (val_reg),
        .idx   (unit_idx),
        .cnt   (cnt_reg),
        .res   (ur)
    );

    // handshake and common conditions
    assign cmd_stall = (state_reg != S_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign out_free  = !out_valid_reg || !res_stall;
    assign unit_idx  = (state_reg == S_IDLE) ? IDX_W'(cmd_data.position_a) : idx_reg;
    assign pa_bad    = (CNT_W'(cmd_data.position_a) >= cnt_reg);
    assign pb_bad    = (CNT_W'(cmd_data.position_b) >= cnt_reg);
    assign ev_hold   = ur.even && pend_valid_reg && !out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_data.mode)
                        MODE_INSERT:
                        begin
                            if (cnt_reg == CNT_W'(CAPACITY))
                                state_next = S_RESP;
                            else if (cnt_reg == '0)
                                state_next = S_INS_PUT;
                            else
                                state_next = S_INS_CHK;
                        end
                        MODE_DELETE:
                        begin
                            if (pa_bad || ur.last)
                                state_next = S_RESP;
                            else
                                state_next = S_DEL;
                        end
                        MODE_SWAP:
                        begin
                            if (pa_bad || pb_bad)
                                state_next = S_RESP;
                            else
                                state_next = S_SWP_B;
                        end
                        MODE_EVENS:
                        begin
                            if (cnt_reg == '0)
                                state_next = S_RESP;
                            else
                                state_next = S_EV;
                        end
                    endcase
                end
            end
            S_INS_CHK:
            begin
                if (ur.ge)
                    state_next = S_INS_SH_RD;
                else if (ur.last)
                    state_next = S_INS_PUT;
            end
            S_INS_SH_RD:
                state_next = S_INS_SH_WR;
            S_INS_SH_WR:
            begin
                if (ur.dec == pos_reg)
                    state_next = S_INS_PUT;
                else
                    state_next = S_INS_SH_RD;
            end
            S_INS_PUT:
                state_next = S_RESP;
            S_DEL:
            begin
                if (ur.last)
                    state_next = S_RESP;
            end
            S_SWP_B:
                state_next = S_SWP_W;
            S_SWP_W:
                state_next = S_SWP_W2;
            S_SWP_W2:
                state_next = S_RESP;
            S_EV:
            begin
                if (!ev_hold && ur.last)
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and store control
    always_comb
    begin
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        status_next     = status_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = rd_data;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        emit            = 1'b0;
        emit_beat       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next     = ST_DONE;
                    pend_valid_next = 1'b0;
                    val_next        = cmd_data.value;
                    unique case (cmd_data.mode)
                        MODE_INSERT:
                        begin
                            idx_next = '0;
                            pos_next = '0;
                            rd_en    = 1'b1;
                            rd_addr  = '0;
                            if (cnt_reg == CNT_W'(CAPACITY))
                                status_next = ST_FULL;
                        end
                        MODE_DELETE:
                        begin
                            if (pa_bad)
                                status_next = ST_RANGE;
                            else if (ur.last)
                                cnt_next = cnt_reg - CNT_W'(1);
                            else
                            begin
                                idx_next = ur.inc[IDX_W-1:0];
                                rd_en    = 1'b1;
                                rd_addr  = ur.inc[IDX_W-1:0];
                            end
                        end
                        MODE_SWAP:
                        begin
                            if (pa_bad || pb_bad)
                                status_next = ST_RANGE;
                            pos_next = IDX_W'(cmd_data.position_a);
                            idx_next = IDX_W'(cmd_data.position_b);
                            rd_en    = 1'b1;
                            rd_addr  = IDX_W'(cmd_data.position_a);
                        end
                        MODE_EVENS:
                        begin
                            idx_next = '0;
                            rd_en    = 1'b1;
                            rd_addr  = '0;
                        end
                    endcase
                end
            end
            // search for the first element not below the new value
            S_INS_CHK:
            begin
                if (ur.ge)
                begin
                    pos_next = idx_reg;
                    idx_next = cnt_reg[IDX_W-1:0];
                end
                else if (ur.last)
                begin
                    pos_next = cnt_reg[IDX_W-1:0];
                end
                else
                begin
                    idx_next = ur.inc[IDX_W-1:0];
                    rd_en    = 1'b1;
                    rd_addr  = ur.inc[IDX_W-1:0];
                end
            end
            // open the gap, moving the tail up one slot at a time
            S_INS_SH_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = ur.dec;
            end
            S_INS_SH_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = rd_data;
                idx_next = ur.dec;
            end
            S_INS_PUT:
            begin
                wr_en    = 1'b1;
                wr_addr  = pos_reg;
                wr_data  = val_reg;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            // close the gap, moving the tail down
            S_DEL:
            begin
                wr_en   = 1'b1;
                wr_addr = ur.dec;
                wr_data = rd_data;
                if (ur.last)
                    cnt_next = cnt_reg - CNT_W'(1);
                else
                begin
                    idx_next = ur.inc[IDX_W-1:0];
                    rd_en    = 1'b1;
                    rd_addr  = ur.inc[IDX_W-1:0];
                end
            end
            // swap: hold first value, read second, write both
            S_SWP_B:
            begin
                val_next = rd_data;
                rd_en    = 1'b1;
                rd_addr  = idx_reg;
            end
            S_SWP_W:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                wr_data = rd_data;
            end
            S_SWP_W2:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = val_reg;
            end
            // readout keeps one even value pending to know which is last
            S_EV:
            begin
                if (!ev_hold)
                begin
                    if (ur.even)
                    begin
                        if (pend_valid_reg)
                        begin
                            emit                 = 1'b1;
                            emit_beat.status     = ST_DONE;
                            emit_beat.item_value = pend_reg;
                            emit_beat.item_valid = 1'b1;
                            emit_beat.last_item  = 1'b0;
                            emit_beat.length     = LEN_W'(cnt_reg);
                        end
                        pend_next       = rd_data;
                        pend_valid_next = 1'b1;
                    end
                    if (!ur.last)
                    begin
                        idx_next = ur.inc[IDX_W-1:0];
                        rd_en    = 1'b1;
                        rd_addr  = ur.inc[IDX_W-1:0];
                    end
                end
            end
            // final beat of every command
            S_RESP:
            begin
                if (out_free)
                begin
                    emit                 = 1'b1;
                    emit_beat.status     = status_reg;
                    emit_beat.item_value = pend_valid_reg ? pend_reg : '0;
                    emit_beat.item_valid = pend_valid_reg;
                    emit_beat.last_item  = 1'b1;
                    emit_beat.length     = LEN_W'(cnt_reg);
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = emit_beat;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        pend_reg   <= pend_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

endmodule
